@@ rtl/sensor_command_fsm_with_page_reader_macros.svh @@
`ifndef SENSOR_COMMAND_FSM_WITH_PAGE_READER_MACROS_SVH
`define SENSOR_COMMAND_FSM_WITH_PAGE_READER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfr: check failed");

// next-cycle implication, sampled on clk, off during reset
`define SCFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfr: check failed");

`endif

@@ rtl/scfr_pkg.sv @@
package scfr_pkg;

  localparam int unsigned PAGE_COUNT = 65536;
  localparam logic [15:0] PAGE_LAST  = 16'(PAGE_COUNT - 1);

  localparam logic [7:0] NOTHING_READ = 8'hFF;
  localparam logic [6:0] WORD_END     = 7'd127;
  localparam logic [7:0] LAST_WORD    = 8'd126;

  localparam logic [2:0] FUNC_STATUS   = 3'd0;
  localparam logic [2:0] FUNC_RESET    = 3'd1;
  localparam logic [2:0] FUNC_START    = 3'd2;
  localparam logic [2:0] FUNC_STOP     = 3'd3;
  localparam logic [2:0] FUNC_GET_DATA = 3'd4;
  localparam logic [2:0] FUNC_RESEND   = 3'd5;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_REPLAY = 2'd2;

  localparam logic [2:0] CODE_CRC_ERR    = 3'd0;
  localparam logic [2:0] CODE_SENSOR_ID  = 3'd1;
  localparam logic [2:0] CODE_FAULT      = 3'd2;
  localparam logic [2:0] CODE_READY      = 3'd3;
  localparam logic [2:0] CODE_NOT_READY  = 3'd4;
  localparam logic [2:0] CODE_STARTED    = 3'd5;
  localparam logic [2:0] CODE_STOPPED    = 3'd6;
  localparam logic [2:0] CODE_RESET_DONE = 3'd7;

  localparam logic [1:0] CTL_NONE  = 2'd0;
  localparam logic [1:0] CTL_START = 2'd1;
  localparam logic [1:0] CTL_STOP  = 2'd2;
  localparam logic [1:0] CTL_RESET = 2'd3;

  typedef enum logic [2:0] {
    MODE_CONN,
    MODE_READY,
    MODE_MEAS,
    MODE_EXCH,
    MODE_MEXCH,
    MODE_RESET
  } mode_t;

  typedef struct packed {
    logic [2:0]  func;
    logic        crc_ok;
    logic        self_check_ok;
    logic [15:0] write_page;
    logic [6:0]  write_word_offset;
    logic        reset_done_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [2:0]  status_code;
    logic [7:0]  ready_bytes;
    logic [15:0] data_page;
    logic [7:0]  data_start;
    logic [7:0]  data_count;
    logic [2:0]  mode_now;
    logic [1:0]  measure_ctl;
  } out_item_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] read_page;
    logic [7:0]  read_word_last;
    logic [7:0]  ready_count;
    logic [1:0]  prev_kind;
    logic [2:0]  prev_code;
    logic        prev_was_status;
    logic [15:0] prev_data_page;
    logic [7:0]  prev_data_start;
    logic [7:0]  prev_data_count;
  } state_t;

  localparam state_t STATE_INIT = '{
    mode:            MODE_CONN,
    read_page:       16'd0,
    read_word_last:  NOTHING_READ,
    ready_count:     8'd0,
    prev_kind:       KIND_RESP,
    prev_code:       CODE_CRC_ERR,
    prev_was_status: 1'b0,
    prev_data_page:  16'd0,
    prev_data_start: 8'd0,
    prev_data_count: 8'd0
  };

endpackage

@@ rtl/scfr_step.sv @@
module scfr_step (
  input  scfr_pkg::state_t    st,
  input  scfr_pkg::in_item_t  item,
  output scfr_pkg::state_t    st_nxt,
  output scfr_pkg::out_item_t res,
  output logic                has_res
);

  function automatic logic [7:0] ready_calc(
    input logic [15:0] rp,
    input logic [7:0]  rwl,
    input logic [15:0] wp,
    input logic [6:0]  wo
  );
    logic signed [10:0] last_s;
    logic signed [10:0] end_s;
    logic signed [10:0] diff_s;
    logic [7:0]         rdy;
    last_s = (rwl == scfr_pkg::NOTHING_READ) ? -11'sd1 : $signed({3'b000, rwl});
    end_s  = (rp == wp) ? $signed({4'b0000, wo}) : $signed({4'b0000, scfr_pkg::WORD_END});
    diff_s = end_s - last_s - 11'sd1;
    if ((rp == wp) && (rwl == {1'b0, wo})) begin
      rdy = 8'd0;
    end else if (diff_s > 11'sd0) begin
      rdy = {diff_s[6:0], 1'b0};
    end else begin
      rdy = 8'd0;
    end
    return rdy;
  endfunction

  logic [7:0]         rdy_cur;
  logic [7:0]         rdy_adv;
  logic [15:0]        adv_page;
  logic [7:0]         adv_rwl;
  logic signed [10:0] last_cur;
  logic signed [10:0] last_sum;
  logic [7:0]         rwl_p1;
  logic [7:0]         data_start;

  logic               rsp_en;
  logic [2:0]         rsp_code;
  logic               rsp_status;
  logic [1:0]         rsp_ctl;
  logic               data_en;
  logic               replay_en;
  logic               rst_en;
  logic               replay_fresh;

  assign rdy_cur = ready_calc(st.read_page, st.read_word_last,
                              item.write_page, item.write_word_offset);

  assign last_cur = (st.read_word_last == scfr_pkg::NOTHING_READ) ?
                    -11'sd1 : $signed({3'b000, st.read_word_last});
  assign last_sum = last_cur + $signed({4'b0000, st.ready_count[7:1]});
  assign rwl_p1     = st.read_word_last + 8'd1;
  assign data_start = {rwl_p1[6:0], 1'b0};

  always_comb begin
    adv_page = st.read_page;
    adv_rwl  = st.read_word_last;
    if (st.ready_count != 8'd0) begin
      if (last_sum >= $signed({3'b000, scfr_pkg::LAST_WORD})) begin
        adv_page = (st.read_page >= scfr_pkg::PAGE_LAST) ? 16'd0 : st.read_page + 16'd1;
        adv_rwl  = scfr_pkg::NOTHING_READ;
      end else if (last_sum < 11'sd0) begin
        adv_rwl = scfr_pkg::NOTHING_READ;
      end else begin
        adv_rwl = last_sum[7:0];
      end
    end
  end

  assign rdy_adv = ready_calc(adv_page, adv_rwl, item.write_page, item.write_word_offset);

  assign replay_fresh = (st.prev_kind == scfr_pkg::KIND_DATA) || st.prev_was_status;

  always_comb begin
    st_nxt     = st;
    rsp_en     = 1'b0;
    rsp_code   = scfr_pkg::CODE_CRC_ERR;
    rsp_status = 1'b0;
    rsp_ctl    = scfr_pkg::CTL_NONE;
    data_en    = 1'b0;
    replay_en  = 1'b0;
    rst_en     = 1'b0;

    if (!item.crc_ok) begin
      rsp_en = 1'b1;
    end else if (st.mode == scfr_pkg::MODE_RESET) begin
      if ((item.func == scfr_pkg::FUNC_STATUS) && item.reset_done_flag) begin
        st_nxt.mode = scfr_pkg::MODE_CONN;
        rsp_en      = 1'b1;
        rsp_code    = scfr_pkg::CODE_RESET_DONE;
      end
    end else if (item.func == scfr_pkg::FUNC_RESET) begin
      st_nxt.mode           = scfr_pkg::MODE_RESET;
      st_nxt.read_page      = 16'd0;
      st_nxt.read_word_last = scfr_pkg::NOTHING_READ;
      st_nxt.ready_count    = 8'd0;
      rst_en                = 1'b1;
    end else if (item.func == scfr_pkg::FUNC_RESEND) begin
      replay_en = 1'b1;
      if (replay_fresh) begin
        st_nxt.ready_count = rdy_cur;
      end
    end else begin
      case (st.mode)
        scfr_pkg::MODE_CONN, scfr_pkg::MODE_READY: begin
          if (item.func == scfr_pkg::FUNC_STATUS) begin
            rsp_en     = 1'b1;
            rsp_status = 1'b1;
            if (!item.self_check_ok) begin
              rsp_code = scfr_pkg::CODE_FAULT;
            end else begin
              rsp_code           = scfr_pkg::CODE_SENSOR_ID;
              st_nxt.ready_count = rdy_cur;
              st_nxt.mode = (rdy_cur != 8'd0) ? scfr_pkg::MODE_EXCH : scfr_pkg::MODE_READY;
            end
          end else if ((item.func == scfr_pkg::FUNC_START) &&
                       (st.mode == scfr_pkg::MODE_READY)) begin
            st_nxt.mode = scfr_pkg::MODE_MEAS;
            rsp_en      = 1'b1;
            rsp_code    = scfr_pkg::CODE_STARTED;
            rsp_ctl     = scfr_pkg::CTL_START;
          end
        end
        scfr_pkg::MODE_MEAS, scfr_pkg::MODE_EXCH, scfr_pkg::MODE_MEXCH: begin
          if (item.func == scfr_pkg::FUNC_GET_DATA) begin
            if (st.mode == scfr_pkg::MODE_MEAS) begin
              st_nxt.mode = scfr_pkg::MODE_MEXCH;
            end else begin
              data_en               = 1'b1;
              st_nxt.read_page      = adv_page;
              st_nxt.read_word_last = adv_rwl;
              st_nxt.ready_count    = rdy_adv;
            end
          end else if (item.func == scfr_pkg::FUNC_STATUS) begin
            rsp_en             = 1'b1;
            rsp_status         = 1'b1;
            st_nxt.ready_count = rdy_cur;
            if (rdy_cur != 8'd0) begin
              rsp_code = scfr_pkg::CODE_READY;
            end else begin
              rsp_code    = scfr_pkg::CODE_NOT_READY;
              st_nxt.mode = (st.mode == scfr_pkg::MODE_EXCH) ?
                            scfr_pkg::MODE_READY : scfr_pkg::MODE_MEAS;
            end
          end else if ((item.func == scfr_pkg::FUNC_STOP) &&
                       (st.mode != scfr_pkg::MODE_EXCH)) begin
            st_nxt.mode = (st.mode == scfr_pkg::MODE_MEAS) ?
                          scfr_pkg::MODE_READY : scfr_pkg::MODE_EXCH;
            rsp_en      = 1'b1;
            rsp_code    = scfr_pkg::CODE_STOPPED;
            rsp_ctl     = scfr_pkg::CTL_STOP;
          end else if ((item.func == scfr_pkg::FUNC_START) &&
                       (st.mode == scfr_pkg::MODE_EXCH)) begin
            st_nxt.mode = scfr_pkg::MODE_MEXCH;
            rsp_en      = 1'b1;
            rsp_code    = scfr_pkg::CODE_STARTED;
            rsp_ctl     = scfr_pkg::CTL_START;
          end
        end
        default: begin
        end
      endcase
    end

    res     = '0;
    has_res = rsp_en | data_en | replay_en | rst_en;

    if (rsp_en) begin
      res.frame_kind         = scfr_pkg::KIND_RESP;
      res.status_code        = rsp_code;
      res.ready_bytes        = rsp_status ? st_nxt.ready_count : 8'd0;
      res.measure_ctl        = rsp_ctl;
      st_nxt.prev_kind       = scfr_pkg::KIND_RESP;
      st_nxt.prev_code       = rsp_code;
      st_nxt.prev_was_status = rsp_status;
      st_nxt.prev_data_page  = 16'd0;
      st_nxt.prev_data_start = 8'd0;
      st_nxt.prev_data_count = 8'd0;
    end
    if (data_en) begin
      res.frame_kind         = scfr_pkg::KIND_DATA;
      res.ready_bytes        = rdy_adv;
      res.data_page          = st.read_page;
      res.data_start         = data_start;
      res.data_count         = st.ready_count;
      st_nxt.prev_kind       = scfr_pkg::KIND_DATA;
      st_nxt.prev_code       = scfr_pkg::CODE_CRC_ERR;
      st_nxt.prev_was_status = 1'b0;
      st_nxt.prev_data_page  = st.read_page;
      st_nxt.prev_data_start = data_start;
      st_nxt.prev_data_count = st.ready_count;
    end
    if (replay_en) begin
      res.frame_kind  = scfr_pkg::KIND_REPLAY;
      res.status_code = st.prev_code;
      res.ready_bytes = replay_fresh ? rdy_cur : 8'd0;
      res.data_page   = st.prev_data_page;
      res.data_start  = st.prev_data_start;
      res.data_count  = st.prev_data_count;
    end
    if (rst_en) begin
      res.frame_kind  = scfr_pkg::KIND_RESP;
      res.measure_ctl = scfr_pkg::CTL_RESET;
    end
    res.mode_now = st_nxt.mode;
  end

endmodule

@@ rtl/sensor_command_fsm_with_page_reader.sv @@
// An accepted item is registered in the input register, worked out by the step
// logic and its result registered in the result register. Throughput: one item
// per cycle when out_stall is low; the input register and the result register
// each take a new item whenever their downstream side moves.
// Reset (rst_n low, synchronous): both registers empty, mode connected,
// read pointer at page 0 with nothing read, replay set to a CRC-error response.
module sensor_command_fsm_with_page_reader (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scfr_pkg::out_item_t out_data
);

  logic                in_valid_r;
  scfr_pkg::in_item_t  in_data_r;
  logic                out_valid_r;
  scfr_pkg::out_item_t out_data_r;
  scfr_pkg::state_t    state_r;
  scfr_pkg::state_t    state_nxt;
  scfr_pkg::out_item_t res;
  logic                has_res;
  logic                advance;

  scfr_step u_step (
    .st      (state_r),
    .item    (in_data_r),
    .st_nxt  (state_nxt),
    .res     (res),
    .has_res (has_res)
  );

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= scfr_pkg::STATE_INIT;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= has_res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance && has_res) begin
      out_data_r <= res;
    end
  end

endmodule

@@ rtl/scfr_checker.sv @@
`include "sensor_command_fsm_with_page_reader_macros.svh"

module scfr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input scfr_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input scfr_pkg::out_item_t out_data
);

  logic kind_ok;
  logic is_data;
  logic data_clean;
  logic is_reset_ctl;
  logic reset_frame;

  assign kind_ok      = (out_data.frame_kind == scfr_pkg::KIND_DATA) ||
                        (out_data.frame_kind == scfr_pkg::KIND_RESP) ||
                        (out_data.frame_kind == scfr_pkg::KIND_REPLAY);
  assign is_data      = out_valid && (out_data.frame_kind == scfr_pkg::KIND_DATA);
  assign data_clean   = (out_data.status_code == scfr_pkg::CODE_CRC_ERR) &&
                        (out_data.measure_ctl == scfr_pkg::CTL_NONE);
  assign is_reset_ctl = out_valid && (out_data.measure_ctl == scfr_pkg::CTL_RESET);
  assign reset_frame  = (out_data.mode_now == scfr_pkg::MODE_RESET) &&
                        (out_data.frame_kind == scfr_pkg::KIND_RESP);

  `SCFR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
  `SCFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SCFR_ASSERT_NOW(a_kind_legal, out_valid, kind_ok)
  `SCFR_ASSERT_NOW(a_data_clean, is_data, data_clean)
  `SCFR_ASSERT_NOW(a_reset_mode, is_reset_ctl, reset_frame)

endmodule

bind sensor_command_fsm_with_page_reader scfr_checker u_scfr_checker (.*);
